>>> hdl/uep_pkg.sv
// shared types, constants and helper functions of the url percent encoder
package uep_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    // what the back end has to emit for one queued command
    localparam logic [1:0] KIND_NONE  = 2'd0;  // end marker only
    localparam logic [1:0] KIND_PLAIN = 2'd1;  // byte passes through
    localparam logic [1:0] KIND_ESC   = 2'd2;  // percent and two hex digits

    localparam logic [1:0] ESC_LAST_PHASE = 2'd2;

    // configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] ASCII_MAX  = 8'd127;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // escape bitmaps, bit i covers character 32 + i
    localparam logic [95:0] FULL_TABLE = 96'hB800_0001_7800_0000_5000_0025;
    localparam logic [95:0] COMP_TABLE = 96'hB800_0001_7800_0001_FC00_987D;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
        logic       trunc;
    } t_cmd;

    function automatic logic needs_escape(input logic [7:0] b, input logic mode);
        logic [6:0]  idx;
        logic [95:0] tab;
        idx = 7'(b - CTRL_LIMIT);
        tab = mode ? COMP_TABLE : FULL_TABLE;
        if (b < CTRL_LIMIT || b > ASCII_MAX) begin
            return 1'b1;
        end
        return tab[idx];
    endfunction

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'h0, n};
        end
        return 8'h37 + {4'h0, n};
    endfunction

endpackage

>>> hdl/uep_front.sv
// front end: classifies each byte, applies the output limit, keeps stream state
module uep_front import uep_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_mode,
    input  logic [15:0]            i_limit,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_last_in,
    input  logic                   i_accept,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    output logic [COUNT_WIDTH-1:0] o_base
);

    localparam logic [32:0] CMAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_stopped, n_stopped;
    logic                   r_dropped, n_dropped;

    logic [32:0]            lim_w;
    logic [COUNT_WIDTH-1:0] lim;
    logic                   esc;
    logic                   fit;
    logic                   emit;
    logic                   drop_now;

    // clip the limit to what the counter can hold
    assign lim_w = (33'(i_limit) > CMAX) ? CMAX : 33'(i_limit);
    assign lim   = COUNT_WIDTH'(lim_w);

    assign esc = needs_escape(i_in_byte, i_mode);

    always_comb begin
        if (esc) begin
            fit = ({2'b00, r_cnt} + (COUNT_WIDTH+2)'(3)) <= {2'b00, lim};
        end else begin
            fit = r_cnt < lim;
        end
    end

    assign emit     = !r_stopped && fit;
    assign drop_now = !emit;

    assign o_cmd.data  = i_in_byte;
    assign o_cmd.kind  = emit ? (esc ? KIND_ESC : KIND_PLAIN) : KIND_NONE;
    assign o_cmd.last  = i_last_in;
    assign o_cmd.trunc = r_dropped | drop_now;
    assign o_base      = r_cnt;
    assign o_push      = i_accept && (emit || i_last_in);

    always_comb begin
        n_cnt     = r_cnt;
        n_stopped = r_stopped;
        n_dropped = r_dropped;
        if (i_accept) begin
            if (i_last_in) begin
                n_cnt     = '0;
                n_stopped = 1'b0;
                n_dropped = 1'b0;
            end else begin
                if (emit) begin
                    n_cnt = r_cnt + (esc ? COUNT_WIDTH'(3) : COUNT_WIDTH'(1));
                end
                n_stopped = r_stopped | drop_now;
                n_dropped = r_dropped | drop_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_stopped <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
            r_dropped <= n_dropped;
        end
    end

endmodule

>>> hdl/uep_queue.sv
// small register queue between front end and back end
module uep_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

>>> hdl/uep_back.sv
// back end: expands queued commands into output words behind an output register
module uep_back import uep_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_head_valid,
    input  t_cmd                   i_head,
    input  logic [COUNT_WIDTH-1:0] i_base,
    output logic                   o_head_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_end_of_stream,
    output logic [15:0]            o_bytes_written,
    output logic                   o_was_truncated
);

    logic [1:0]             r_phase, n_phase;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_byte;
    logic                   r_bvalid;
    logic                   r_eos;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic                   r_trunc;

    logic [7:0]             w_byte;
    logic                   w_bvalid;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic                   w_final;
    logic                   load;

    // word for the current phase of the head command
    always_comb begin
        w_byte   = 8'h00;
        w_bvalid = 1'b0;
        w_cnt    = i_base;
        w_final  = 1'b1;
        unique case (i_head.kind)
            KIND_ESC: begin
                w_bvalid = 1'b1;
                w_cnt    = i_base + COUNT_WIDTH'(r_phase) + COUNT_WIDTH'(1);
                w_final  = (r_phase == ESC_LAST_PHASE);
                if (r_phase == 2'd0) begin
                    w_byte = PCT_CHAR;
                end else if (r_phase == 2'd1) begin
                    w_byte = hex_char(i_head.data[7:4] & NIBBLE_MASK);
                end else begin
                    w_byte = hex_char(i_head.data[3:0] & NIBBLE_MASK);
                end
            end
            KIND_PLAIN: begin
                w_byte   = i_head.data;
                w_bvalid = 1'b1;
                w_cnt    = i_base + COUNT_WIDTH'(1);
            end
            default: begin
                // end marker
                w_byte   = 8'h00;
                w_bvalid = 1'b0;
            end
        endcase
    end

    assign load       = i_head_valid && (!r_out_valid || pop);
    assign o_head_pop = load && w_final;

    always_comb begin
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        if (load) begin
            n_phase     = w_final ? 2'd0 : r_phase + 2'd1;
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= w_byte;
            r_bvalid <= w_bvalid;
            r_eos    <= i_head.last && w_final;
            r_cnt    <= w_cnt;
            r_trunc  <= i_head.trunc;
        end
    end

    assign empty           = !r_out_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_end_of_stream = r_eos;
    assign o_bytes_written = 16'(r_cnt);
    assign o_was_truncated = r_trunc;

endmodule

>>> hdl/url_percent_encoder.sv
// top level of the streaming url percent encoder
//
// usage
//   input channel: drive i_in_byte and i_last_in with push high; a word is
//   taken at each clock edge where push is high and full is low. i_last_in
//   marks the final byte of a string.
//   result channel: while empty is low the oldest result word sits on the
//   o_ ports; pop high takes it at the clock edge. a plain byte gives one
//   word, an escaped byte gives '%' and two upper-case hex digits. the last
//   byte's final word carries o_end_of_stream; if that byte gave nothing, a
//   lone end marker word with o_byte_valid low is sent instead.
//   config: apb port, component_mode at 0x0, out_limit at 0x4; write only
//   while the block is idle.
// flow
//   a taken word passes the command queue and the output register before
//   its first result word shows. the front end takes one byte per cycle
//   while full is low into a 4-entry command queue; the back end drains
//   one word per cycle while pop is high; escaped bytes take three words.
// reset and stall
//   synchronous active-low reset clears the stream count and flags, the queue
//   and the output register; component_mode goes to 0, out_limit to 65535.
//   a stalled receiver holds the output word, the queue fills, then full rises.
module url_percent_encoder import uep_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_in,
    // result words
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_stream,
    output logic [15:0] o_bytes_written,
    output logic        o_was_truncated,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CMD_W = $bits(t_cmd) + COUNT_WIDTH;

    // configuration registers
    logic        r_mode;
    logic [15:0] r_limit;
    logic        cfg_wr;

    // front end to queue
    logic                   accept;
    logic                   f_push;
    t_cmd                   f_cmd;
    logic [COUNT_WIDTH-1:0] f_base;

    // queue to back end
    logic [CMD_W-1:0]       q_rdata;
    logic                   q_empty;
    logic                   q_pop;
    t_cmd                   h_cmd;
    logic [COUNT_WIDTH-1:0] h_base;

    // apb register file, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_limit <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODE:  r_mode  <= pwdata[0];
                REG_LIMIT: r_limit <= pwdata[15:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE:  prdata = {31'd0, r_mode};
            REG_LIMIT: prdata = {16'd0, r_limit};
            default:   prdata = 32'd0;
        endcase
    end

    // an input word is taken whenever the command queue has room
    assign accept = push && !full;

    uep_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_limit   (r_limit),
        .i_in_byte (i_in_byte),
        .i_last_in (i_last_in),
        .i_accept  (accept),
        .o_push    (f_push),
        .o_cmd     (f_cmd),
        .o_base    (f_base)
    );

    // commands that produce no word (dropped mid-stream bytes) never enter
    uep_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_cmd, f_base}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign h_cmd  = q_rdata[CMD_W-1 -: $bits(t_cmd)];
    assign h_base = q_rdata[COUNT_WIDTH-1:0];

    uep_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (!q_empty),
        .i_head          (h_cmd),
        .i_base          (h_base),
        .o_head_pop      (q_pop),
        .pop             (pop),
        .empty           (empty),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_stream (o_end_of_stream),
        .o_bytes_written (o_bytes_written),
        .o_was_truncated (o_was_truncated)
    );

    // a word without a character is always a stream end marker
    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_byte_valid |-> o_end_of_stream)
        else $error("end marker word without end_of_stream");

    // the count shown never passes the configured limit
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_bytes_written <= r_limit)
        else $error("bytes_written beyond out_limit");

    // within a stream the count steps by one per character word
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_end_of_stream |=> empty ||
        (o_byte_valid && o_bytes_written == 16'($past(o_bytes_written) + 16'd1)) ||
        (!o_byte_valid && o_bytes_written == $past(o_bytes_written)))
        else $error("bytes_written out of sequence");

endmodule

>>> tb/enc_check_pkg.sv
// result word type and scoreboard class for the url percent encoder testbench
`timescale 1ns / 100ps

package enc_check_pkg;

    localparam bit [7:0] PERCENT    = 8'h25;
    localparam bit [7:0] DIGIT_ZERO = 8'h30;
    localparam bit [7:0] LETTER_A   = 8'h41;
    localparam bit [7:0] CTRL_END   = 8'd32;
    localparam bit [7:0] ASCII_TOP  = 8'd127;

    // escape sets, row r bit k covers character 32 + 8*r + k
    localparam bit [7:0] URL_SET [12]  = '{37, 0, 0, 80, 0, 0, 0, 120, 1, 0, 0, 184};
    localparam bit [7:0] COMP_SET [12] = '{125, 152, 0, 252, 1, 0, 0, 120, 1, 0, 0, 184};

    typedef struct packed {
        bit [7:0]  ch;
        bit        valid;
        bit        eos;
        bit [15:0] count;
        bit        trunc;
    } t_enc_word;

    class t_encode_scoreboard;
        bit        mode;
        bit [15:0] limit;
        bit [15:0] count;
        bit        stopped;
        bit        dropped;
        t_enc_word pending[$];
        int        mismatches;
        int        words_checked;
        int        items_taken;
        int        strings_done;
        int        strings_cut;

        function new();
            mode  = 1'b0;
            limit = 16'hFFFF;
        endfunction

        function bit escapes(bit [7:0] b);
            bit [6:0] idx;
            bit [7:0] row;
            if (b < CTRL_END || b > ASCII_TOP) begin
                return 1'b1;
            end
            idx = 7'(b - CTRL_END);
            row = mode ? COMP_SET[idx[6:3]] : URL_SET[idx[6:3]];
            return row[idx[2:0]];
        endfunction

        function bit [7:0] hex_digit(bit [3:0] n);
            return (n < 4'd10) ? DIGIT_ZERO + 8'(n) : LETTER_A + 8'(n) - 8'd10;
        endfunction

        function t_enc_word make_word(bit [7:0] ch, bit valid);
            t_enc_word w;
            w.ch    = ch;
            w.valid = valid;
            w.eos   = 1'b0;
            w.count = count;
            w.trunc = dropped;
            return w;
        endfunction

        function t_enc_word emit(bit [7:0] ch);
            count++;
            return make_word(ch, 1'b1);
        endfunction

        // expected words for one accepted source byte
        function void take_byte(bit [7:0] b, bit last);
            t_enc_word w[3];
            int n;
            n = 0;
            items_taken++;
            if (!stopped) begin
                if (escapes(b)) begin
                    if (32'(count) + 32'd3 > 32'(limit)) begin
                        stopped = 1'b1;
                        dropped = 1'b1;
                    end else begin
                        w[0] = emit(PERCENT);
                        w[1] = emit(hex_digit(b[7:4]));
                        w[2] = emit(hex_digit(b[3:0]));
                        n = 3;
                    end
                end else if (count >= limit) begin
                    stopped = 1'b1;
                    dropped = 1'b1;
                end else begin
                    w[0] = emit(b);
                    n = 1;
                end
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                if (n == 0) begin
                    w[0] = make_word(8'h00, 1'b0);
                    n = 1;
                end
                w[n-1].eos = 1'b1;
                strings_done++;
                if (dropped) begin
                    strings_cut++;
                end
                count   = '0;
                stopped = 1'b0;
                dropped = 1'b0;
            end
            for (int i = 0; i < n; i++) begin
                pending.push_back(w[i]);
            end
        endfunction

        function void report(string what, t_enc_word want, t_enc_word got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t %s: expected ch=%h valid=%b eos=%b count=%0d trunc=%b,",
                         $realtime, what, want.ch, want.valid, want.eos, want.count,
                         want.trunc);
                $display("    got ch=%h valid=%b eos=%b count=%0d trunc=%b",
                         got.ch, got.valid, got.eos, got.count, got.trunc);
            end
        endfunction

        function void check_word(t_enc_word got);
            t_enc_word want;
            words_checked++;
            if (pending.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.ch != want.ch || got.valid != want.valid || got.eos != want.eos ||
                got.count != want.count || got.trunc != want.trunc) begin
                report("word mismatch", want, got);
            end
        endfunction
    endclass

endpackage

>>> tb/tb.sv
// top level testbench of the url percent encoder
`timescale 1ns / 100ps

module tb;
    import uep_pkg::*;
    import enc_check_pkg::*;

    // worst case the block holds a 4-deep command queue of escapes plus the output word
    localparam int DRAIN_CYCLES = 24;
    localparam int RAND_ITEMS_PER_SETTING = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_in_byte = '0;
    logic        i_last_in = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_end_of_stream;
    logic [15:0] o_bytes_written;
    logic        o_was_truncated;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_encode_scoreboard board;
    int          tx_idle_pct = 8;
    int          rx_idle_pct = 73;
    t_enc_word   seen;

    url_percent_encoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_last_in       (i_last_in),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_stream (o_end_of_stream),
        .o_bytes_written (o_bytes_written),
        .o_was_truncated (o_was_truncated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random pop, stall rate set per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // outputs only move at rising edges, so the value at the falling edge is the
    // one the block hands over at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen.ch    = o_out_byte;
            seen.valid = o_byte_valid;
            seen.eos   = o_end_of_stream;
            seen.count = o_bytes_written;
            seen.trunc = o_was_truncated;
            board.check_word(seen);
        end
    end

    // one source byte, held until the block takes it
    task automatic send_byte(input bit [7:0] b, input bit last);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        i_last_in <= last;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
        board.take_byte(b, last);
    endtask

    // mostly printable text, a good share of arbitrary bytes, and the edges
    function automatic bit [7:0] pick_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) begin
            return 8'($urandom_range(32, 126));
        end else if (sel < 80) begin
            return 8'($urandom);
        end
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'h1F;
            2: return 8'h20;
            3: return 8'h7F;
            4: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1);
        end
    endtask

    // wait for every expected word, then let the queue settle
    task automatic settle_block();
        push <= 1'b0;
        while (board.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic which, input bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_MODE) begin
            board.mode = value[0];
        end else begin
            board.limit = value[15:0];
        end
    endtask

    task automatic set_encoding(input bit mode, input bit [15:0] limit);
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_LIMIT, 32'(limit));
    endtask

    // directed strings: escape boundaries, both tables, and the limit cases
    task automatic run_directed();
        bit [7:0] mixed[10] = '{8'h00, 8'h1F, 8'h20, 8'h21, 8'h25,
                                8'h7F, 8'h80, 8'hFF, 8'h41, 8'h2F};
        set_encoding(1'b0, 16'hFFFF);
        foreach (mixed[i]) begin
            send_byte(mixed[i], i == 9);
        end
        settle_block();
        // component table escapes '/' and space, keeps '~'
        set_encoding(1'b1, 16'hFFFF);
        send_byte(8'h2F, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h20, 1'b1);
        settle_block();
        // escape fills the limit exactly, next plain byte hits the full limit,
        // and the one after stays dropped
        set_encoding(1'b1, 16'd4);
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        settle_block();
        // escape that does not fit, then a byte that would fit
        set_encoding(1'b0, 16'd2);
        send_byte(8'h61, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h62, 1'b1);
        settle_block();
        // zero limit: last byte gives only the end marker
        set_encoding(1'b0, 16'd0);
        send_byte(8'h7A, 1'b1);
        send_byte(8'hFF, 1'b1);
        settle_block();
    endtask

    bit          set_mode[6]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    bit [15:0]   set_limit[6] = '{16'hFFFF, 16'd3, 16'd0, 16'd16, 16'hFFFF, 16'd1};
    int          tx_idle_by_phase[3] = '{8, 73, 0};
    int          rx_idle_by_phase[3] = '{73, 8, 0};

    initial begin
        int sent;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = tx_idle_by_phase[ph];
            rx_idle_pct = rx_idle_by_phase[ph];
            for (int k = 0; k < 2; k++) begin
                set_encoding(set_mode[ph*2+k], set_limit[ph*2+k]);
                sent = board.items_taken;
                while (board.items_taken - sent < RAND_ITEMS_PER_SETTING) begin
                    // now and then a longer string to run into the mid-size limits
                    send_string(($urandom_range(9) == 0) ? $urandom_range(10, 20)
                                                         : $urandom_range(1, 8));
                end
                settle_block();
            end
        end

        $display("sent %0d bytes in %0d strings, %0d of them cut by the limit",
                 board.items_taken, board.strings_done, board.strings_cut);
        $display("checked %0d words over both tables and six limits, %0d mismatches",
                 board.words_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/uep_pkg.sv
hdl/uep_front.sv
hdl/uep_queue.sv
hdl/uep_back.sv
hdl/url_percent_encoder.sv
tb/enc_check_pkg.sv
tb/tb.sv
